[sv/fastq_record_parser_core_defines.svh]
// Assertion macros shared by the FASTQ record parser checkers.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef FASTQ_RECORD_PARSER_CORE_DEFINES_SVH
`define FASTQ_RECORD_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FQP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fqp_pkg.sv]
// Shared types, codes and constants of the FASTQ record parser.
// No dependencies; used by every module of the block.
`default_nettype none

package fqp_pkg;

    localparam int PAT_MAX    = 8;   // longest terminator in bytes
    localparam int COUNT_BITS = 16;  // width of the length counters
    localparam int LEN_W      = $clog2(PAT_MAX + 1);
    localparam int IDX_W      = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CHAR_AT = 8'h40;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    // "\n+\n", first byte in the low bits
    localparam logic [63:0] TERM_PATTERN_RESET = 64'h0000_0000_000A_2B0A;
    localparam logic [3:0]  TERM_LENGTH_RESET  = 4'd3;

    typedef enum logic [0:0] {
        CFG_TERM_PATTERN = 1'b0,
        CFG_TERM_LENGTH  = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        KIND_DROP    = 3'd0,
        KIND_ID      = 3'd1,
        KIND_SEQ     = 3'd2,
        KIND_QUAL    = 3'd3,
        KIND_HDR_END = 3'd4
    } t_byte_kind;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_DONE      = 3'd1,
        ST_NO_AT     = 3'd2,
        ST_EARLY_END = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_byte_kind  byte_kind;
        logic [15:0] id_length;
        logic [15:0] seq_length;
        t_status     status;
    } t_out_item;

    // Terminator settings after clamping to 1..PAT_MAX
    typedef struct packed {
        logic [63:0]      pattern;
        logic [LEN_W-1:0] used_len;
        logic [IDX_W-1:0] used_idx;
    } t_cfg;

    // Window shift request from the parser
    typedef struct packed {
        logic       shift;
        logic [7:0] data;
    } t_win_ctrl;

endpackage

`default_nettype wire

[sv/fqp_cfg_regs.sv]
// Terminator configuration registers with length clamping.
// Depends on fqp_pkg.
`default_nettype none

module fqp_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire fqp_pkg::t_cfg_index i_wr_index,
    input  wire logic [63:0]       i_wr_data,
    output fqp_pkg::t_cfg          o_cfg
);

    logic [63:0] r_pattern;
    logic [3:0]  r_length;
    logic [3:0]  clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= fqp_pkg::TERM_PATTERN_RESET;
            r_length  <= fqp_pkg::TERM_LENGTH_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                fqp_pkg::CFG_TERM_PATTERN: r_pattern <= i_wr_data;
                fqp_pkg::CFG_TERM_LENGTH:  r_length  <= i_wr_data[3:0];
                default:                   r_length  <= r_length;
            endcase
        end
    end

    // zero acts as one, anything past the window depth as the full depth
    always_comb begin
        if (r_length == 4'd0) begin
            clamped = 4'd1;
        end else if (r_length > 4'(fqp_pkg::PAT_MAX)) begin
            clamped = 4'(fqp_pkg::PAT_MAX);
        end else begin
            clamped = r_length;
        end
    end

    assign o_cfg.pattern  = r_pattern;
    assign o_cfg.used_len = fqp_pkg::LEN_W'(clamped);
    assign o_cfg.used_idx = fqp_pkg::IDX_W'(clamped - 4'd1);

endmodule

`default_nettype wire

[sv/fqp_window.sv]
// Sliding byte window of the sequence phase and parallel terminator compare.
// Depends on fqp_pkg.
`default_nettype none

module fqp_window (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fqp_pkg::t_cfg      i_cfg,
    input  wire fqp_pkg::t_win_ctrl i_ctrl,
    output logic                    o_match
);

    logic [7:0] r_window [fqp_pkg::PAT_MAX];
    logic [7:0] nxt      [fqp_pkg::PAT_MAX];
    logic [fqp_pkg::PAT_MAX-1:0] hit;

    // window as it looks after the candidate byte is shifted in
    always_comb begin
        nxt[0] = i_ctrl.data;
        for (int i = 1; i < fqp_pkg::PAT_MAX; i++) begin
            nxt[i] = r_window[i-1];
        end
    end

    // one compare per terminator length; newest byte matches the last pattern byte
    always_comb begin
        for (int n = 0; n < fqp_pkg::PAT_MAX; n++) begin
            hit[n] = 1'b1;
            for (int i = 0; i <= n; i++) begin
                if (nxt[i] != i_cfg.pattern[8*(n-i) +: 8]) begin
                    hit[n] = 1'b0;
                end
            end
        end
    end

    assign o_match = hit[i_cfg.used_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fqp_pkg::PAT_MAX; i++) begin
                r_window[i] <= 8'h00;
            end
        end else if (i_ctrl.shift) begin
            for (int i = 0; i < fqp_pkg::PAT_MAX; i++) begin
                r_window[i] <= nxt[i];
            end
        end
    end

endmodule

`default_nettype wire

[sv/fqp_parser.sv]
// Record phase machine, length counters and result register.
// Depends on fqp_pkg; pairs with fqp_window for the terminator match.
`default_nettype none

module fqp_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire fqp_pkg::t_in_item i_item,
    input  wire fqp_pkg::t_cfg     i_cfg,
    input  wire logic              i_match,
    input  wire logic              i_out_stall,
    output fqp_pkg::t_win_ctrl     o_win,
    output logic                   o_free,
    output logic                   o_out_valid,
    output fqp_pkg::t_out_item     o_out_data
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_IDENT  = 2'd1,
        PH_SEQ    = 2'd2,
        PH_QUAL   = 2'd3
    } t_phase;

    t_phase                        r_phase,   n_phase;
    logic [fqp_pkg::COUNT_BITS-1:0] r_id,     n_id;
    logic [fqp_pkg::COUNT_BITS-1:0] r_seq,    n_seq;
    logic [fqp_pkg::COUNT_BITS-1:0] r_qual,   n_qual;
    logic                          r_out_valid;
    fqp_pkg::t_out_item            r_out,     n_out;

    logic [fqp_pkg::COUNT_BITS-1:0] seq_inc;
    logic [fqp_pkg::COUNT_BITS-1:0] seq_len;
    logic [fqp_pkg::COUNT_BITS-1:0] qual_dec;
    logic [fqp_pkg::COUNT_BITS-1:0] term_len;
    logic [fqp_pkg::COUNT_BITS-1:0] seq_out;
    logic [7:0]                    b;
    logic                          seq_room;

    assign b        = i_item.end_of_input ? 8'h00 : i_item.in_byte;
    assign term_len = fqp_pkg::COUNT_BITS'(i_cfg.used_len);
    assign seq_inc  = r_seq + 1'b1;
    assign seq_len  = seq_inc - term_len;
    assign qual_dec = (r_qual != '0) ? r_qual - 1'b1 : r_qual;
    assign seq_room = (r_seq != fqp_pkg::CNT_MAX);

    // window advances only on sequence bytes that fit the counter
    assign o_win.shift = i_take && !i_item.end_of_input && (r_phase == PH_SEQ) && seq_room;
    assign o_win.data  = b;

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_seq   = r_seq;
        n_qual  = r_qual;
        seq_out = '0;

        n_out.out_byte  = b;
        n_out.byte_kind = fqp_pkg::KIND_DROP;
        n_out.status    = fqp_pkg::ST_BUSY;

        if (i_item.end_of_input) begin
            if (r_phase != PH_HEADER) begin
                n_out.status = fqp_pkg::ST_EARLY_END;
                n_phase      = PH_HEADER;
            end
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (b == fqp_pkg::CHAR_AT) begin
                        n_out.byte_kind = fqp_pkg::KIND_ID;
                        n_id            = fqp_pkg::COUNT_BITS'(1);
                        n_seq           = '0;
                        n_qual          = '0;
                        n_phase         = PH_IDENT;
                    end else if (b == fqp_pkg::CHAR_NL) begin
                        n_out.status = fqp_pkg::ST_NO_AT;
                    end
                end
                PH_IDENT: begin
                    if (b == fqp_pkg::CHAR_NL) begin
                        n_out.byte_kind = fqp_pkg::KIND_HDR_END;
                        n_seq           = '0;
                        n_phase         = PH_SEQ;
                    end else if (r_id == fqp_pkg::CNT_MAX) begin
                        n_out.status = fqp_pkg::ST_OVERFLOW;
                        n_phase      = PH_HEADER;
                    end else begin
                        n_out.byte_kind = fqp_pkg::KIND_ID;
                        n_id            = r_id + 1'b1;
                    end
                end
                PH_SEQ: begin
                    n_out.byte_kind = fqp_pkg::KIND_SEQ;
                    if (!seq_room) begin
                        n_out.status = fqp_pkg::ST_OVERFLOW;
                        n_phase      = PH_HEADER;
                    end else if ((seq_inc >= term_len) && i_match) begin
                        n_seq   = seq_len;
                        n_qual  = seq_len;
                        seq_out = seq_len;
                        if (seq_len == '0) begin
                            // empty sequence: record ends on the terminator
                            n_out.status = fqp_pkg::ST_DONE;
                            n_phase      = PH_HEADER;
                        end else begin
                            n_phase = PH_QUAL;
                        end
                    end else begin
                        n_seq = seq_inc;
                    end
                end
                PH_QUAL: begin
                    n_out.byte_kind = fqp_pkg::KIND_QUAL;
                    seq_out         = r_seq;
                    n_qual          = qual_dec;
                    if (qual_dec == '0) begin
                        n_out.status = fqp_pkg::ST_DONE;
                        n_phase      = PH_HEADER;
                    end
                end
                default: n_phase = PH_HEADER;
            endcase
        end

        n_out.id_length  = 16'(n_id);
        n_out.seq_length = 16'(seq_out);
    end

    assign o_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_id        <= '0;
            r_seq       <= '0;
            r_qual      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_phase     <= n_phase;
                r_id        <= n_id;
                r_seq       <= n_seq;
                r_qual      <= n_qual;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[sv/fastq_record_parser_core.sv]
// FASTQ record parser: takes one stream byte per transaction and returns one
// tagged result per byte. The block drops bytes until '@', tags identifier
// bytes up to the header newline, then tracks sequence bytes in a sliding
// window until the configured terminator (1 to 8 bytes, "\n+\n" after reset)
// matches, reports the sequence length and tags that many quality bytes.
// Throughput is one byte per clock unless output stalls; bytes pass the input
// register, then the result register. The terminator compare runs on all window
// lengths in parallel, and the phase/counter update is a single compare-and-add
// per byte, so nothing loops. Counters are 16 bits; a byte that would exceed
// them ends the record with an overflow status. The config port is always
// ready; write it only while no transaction is in flight. No clearing pass.
// Depends on fqp_pkg, fqp_cfg_regs, fqp_window and fqp_parser.
`default_nettype none

module fastq_record_parser_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // byte stream in
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fqp_pkg::t_in_item   i_in_data,
    // tagged results out
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fqp_pkg::t_out_item       o_out_data,
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire fqp_pkg::t_cfg_index i_cfg_index,
    input  wire logic [63:0]         i_cfg_data
);

    // input register: holds one accepted transaction until the parser takes it
    logic               r_s1_valid;
    fqp_pkg::t_in_item  r_s1_data;

    logic               out_free;
    logic               take;
    logic               in_accept;
    logic               match;
    fqp_pkg::t_cfg      cfg;
    fqp_pkg::t_win_ctrl win_ctrl;

    assign take       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
    end

    fqp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // window compare sees the byte held in the input register
    fqp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctrl  (win_ctrl),
        .o_match (match)
    );

    fqp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (r_s1_data),
        .i_cfg       (cfg),
        .i_match     (match),
        .i_out_stall (i_out_stall),
        .o_win       (win_ctrl),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[sv/fqp_checker.sv]
// Port-level checker for the FASTQ record parser, bound to the top level.
// Depends on fqp_pkg and fastq_record_parser_core_defines.svh.
`default_nettype none
`include "fastq_record_parser_core_defines.svh"

module fqp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_stall,
    input wire fqp_pkg::t_out_item i_out_data
);

    logic is_hdr_end;
    logic hdr_end_ok;
    logic is_no_at;
    logic no_at_ok;
    logic is_early_end;
    logic early_end_ok;

    assign is_hdr_end   = i_out_valid && (i_out_data.byte_kind == fqp_pkg::KIND_HDR_END);
    assign hdr_end_ok   = (i_out_data.out_byte == fqp_pkg::CHAR_NL) &&
                          (i_out_data.status == fqp_pkg::ST_BUSY);
    assign is_no_at     = i_out_valid && (i_out_data.status == fqp_pkg::ST_NO_AT);
    assign no_at_ok     = (i_out_data.out_byte == fqp_pkg::CHAR_NL) &&
                          (i_out_data.byte_kind == fqp_pkg::KIND_DROP);
    assign is_early_end = i_out_valid && (i_out_data.status == fqp_pkg::ST_EARLY_END);
    assign early_end_ok = (i_out_data.out_byte == 8'h00) &&
                          (i_out_data.byte_kind == fqp_pkg::KIND_DROP);

    `FQP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data),
        "stalled result changed")

    `FQP_ASSERT_NOW(a_hdr_end, i_clk, i_rst_n, is_hdr_end, hdr_end_ok,
        "header end not a plain newline")

    `FQP_ASSERT_NOW(a_no_at, i_clk, i_rst_n, is_no_at, no_at_ok,
        "missing-@ status on wrong byte")

    `FQP_ASSERT_NOW(a_early_end, i_clk, i_rst_n, is_early_end, early_end_ok,
        "early end carries data")

endmodule

bind fastq_record_parser_core fqp_checker u_fqp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire

[dv/fqp_result_checker.sv]
// Result checker for fastq_record_parser_core: tracks the parse state of the
// byte stream, predicts the tagged result of each byte and compares it.
// Depends on fqp_pkg; instantiated by fastq_record_parser_core_tb.
`default_nettype none

module fqp_result_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire fqp_pkg::t_in_item   i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire fqp_pkg::t_out_item  i_out_data,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire fqp_pkg::t_cfg_index i_cfg_index,
    input  wire logic [63:0]         i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_records
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_IDENT,
        PH_SEQ,
        PH_QUAL
    } t_phase;

    logic [63:0]        term_pat;
    logic [3:0]         term_len;
    t_phase             ph;
    logic [7:0]         win [fqp_pkg::PAT_MAX];
    int unsigned        id_cnt;
    int unsigned        seq_cnt;
    int unsigned        qual_left;
    fqp_pkg::t_out_item tagged_q [$];

    // next tagged result for one stream byte; advances the parse state
    function automatic fqp_pkg::t_out_item tag_byte(input fqp_pkg::t_in_item it);
        fqp_pkg::t_out_item r;
        int unsigned        n;
        int                 i;
        logic               hit;
        r.out_byte   = it.in_byte;
        r.byte_kind  = fqp_pkg::KIND_DROP;
        r.seq_length = '0;
        r.status     = fqp_pkg::ST_BUSY;
        if (it.end_of_input) begin
            r.out_byte = '0;
            if (ph != PH_HEADER) begin
                r.status = fqp_pkg::ST_EARLY_END;
                ph       = PH_HEADER;
            end
        end else begin
            case (ph)
                PH_HEADER: begin
                    if (it.in_byte == fqp_pkg::CHAR_AT) begin
                        r.byte_kind = fqp_pkg::KIND_ID;
                        id_cnt      = 1;
                        seq_cnt     = 0;
                        qual_left   = 0;
                        ph          = PH_IDENT;
                    end else if (it.in_byte == fqp_pkg::CHAR_NL) begin
                        r.status = fqp_pkg::ST_NO_AT;
                    end
                end
                PH_IDENT: begin
                    if (it.in_byte == fqp_pkg::CHAR_NL) begin
                        r.byte_kind = fqp_pkg::KIND_HDR_END;
                        seq_cnt     = 0;
                        ph          = PH_SEQ;
                    end else if (id_cnt >= fqp_pkg::CNT_MAX) begin
                        r.status = fqp_pkg::ST_OVERFLOW;
                        ph       = PH_HEADER;
                    end else begin
                        r.byte_kind = fqp_pkg::KIND_ID;
                        id_cnt++;
                    end
                end
                PH_SEQ: begin
                    r.byte_kind = fqp_pkg::KIND_SEQ;
                    if (seq_cnt >= fqp_pkg::CNT_MAX) begin
                        r.status = fqp_pkg::ST_OVERFLOW;
                        ph       = PH_HEADER;
                    end else begin
                        seq_cnt++;
                        for (i = fqp_pkg::PAT_MAX - 1; i > 0; i--) win[i] = win[i-1];
                        win[0] = it.in_byte;
                        n = term_len;
                        if (n == 0) n = 1;
                        if (n > fqp_pkg::PAT_MAX) n = fqp_pkg::PAT_MAX;
                        // newest byte sits in win[0] and lines up with the last pattern byte
                        hit = (seq_cnt >= n);
                        for (i = 0; i < n; i++) begin
                            if (win[i] != term_pat[8*(n-1-i) +: 8]) hit = 1'b0;
                        end
                        if (hit) begin
                            seq_cnt      = seq_cnt - n;
                            qual_left    = seq_cnt;
                            r.seq_length = seq_cnt[15:0];
                            if (qual_left == 0) begin
                                r.status = fqp_pkg::ST_DONE;
                                ph       = PH_HEADER;
                            end else begin
                                ph = PH_QUAL;
                            end
                        end
                    end
                end
                default: begin
                    r.byte_kind  = fqp_pkg::KIND_QUAL;
                    r.seq_length = seq_cnt[15:0];
                    if (qual_left > 0) qual_left--;
                    if (qual_left == 0) begin
                        r.status = fqp_pkg::ST_DONE;
                        ph       = PH_HEADER;
                    end
                end
            endcase
        end
        r.id_length = id_cnt[15:0];
        return r;
    endfunction

    task automatic flag(input string why, input fqp_pkg::t_out_item want,
                        input fqp_pkg::t_out_item got);
        o_errors++;
        if (o_errors <= 10) begin
            $display("checker: %s at %0t", why, $time);
            $display("  expected byte %02h kind %0d id %0d seq %0d status %0d",
                     want.out_byte, want.byte_kind, want.id_length, want.seq_length,
                     want.status);
            $display("  actual   byte %02h kind %0d id %0d seq %0d status %0d",
                     got.out_byte, got.byte_kind, got.id_length, got.seq_length,
                     got.status);
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_records = 0;
    end

    always @(posedge i_clk) begin : watch
        fqp_pkg::t_out_item want;
        int                 i;
        if (!i_rst_n) begin
            term_pat  = fqp_pkg::TERM_PATTERN_RESET;
            term_len  = fqp_pkg::TERM_LENGTH_RESET;
            ph        = PH_HEADER;
            id_cnt    = 0;
            seq_cnt   = 0;
            qual_left = 0;
            for (i = 0; i < fqp_pkg::PAT_MAX; i++) win[i] = '0;
            tagged_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == fqp_pkg::CFG_TERM_PATTERN) term_pat = i_cfg_data;
                else term_len = i_cfg_data[3:0];
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (i_out_data.status == fqp_pkg::ST_DONE) o_records++;
                if (tagged_q.size() == 0) begin
                    flag("result with no byte outstanding", '0, i_out_data);
                end else begin
                    want = tagged_q.pop_front();
                    if (i_out_data.out_byte   !== want.out_byte   ||
                        i_out_data.byte_kind  !== want.byte_kind  ||
                        i_out_data.id_length  !== want.id_length  ||
                        i_out_data.seq_length !== want.seq_length ||
                        i_out_data.status     !== want.status) begin
                        flag("result mismatch", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) tagged_q.push_back(tag_byte(i_in_data));
        end
        o_pending <= tagged_q.size();
    end

endmodule

`default_nettype wire

[dv/fastq_record_parser_core_tb.sv]
// Testbench top for fastq_record_parser_core: drives FASTQ byte streams and
// terminator settings, lets fqp_result_checker judge every result.
// Depends on fqp_pkg, fastq_record_parser_core and fqp_result_checker.
`default_nettype none

module fastq_record_parser_core_tb;

    // cycles without any accepted transaction before the run is called hung
    localparam int          HANG_LIMIT = 5000;
    localparam logic [39:0] BASES      = "ACGTN";

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    fqp_pkg::t_in_item   in_item;
    logic                out_valid;
    logic                out_stall;
    fqp_pkg::t_out_item  out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    fqp_pkg::t_cfg_index cfg_index;
    logic [63:0]         cfg_data;

    int errors;
    int pending;
    int results;
    int records;

    // stimulus-side view of the terminator, used to build records that end properly
    logic [63:0] term_pat  = fqp_pkg::TERM_PATTERN_RESET;
    int unsigned term_used = fqp_pkg::TERM_LENGTH_RESET;

    int src_idle_pct;
    int sink_stall_pct;
    int bytes_sent;
    int settings_used;
    int hang_cycles;

    always #5 clk = ~clk;

    fastq_record_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fqp_result_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_records   (records)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // hang watchdog: any accepted transaction on any channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
        if (hang_cycles >= HANG_LIMIT) begin
            $display("fastq_record_parser_core_tb: done, errors");
            $finish;
        end
    end

    // One stream transaction. Valid stays high after acceptance; the next call
    // or quiet_and_drain decides what it does at this falling edge.
    task automatic push_item(input logic [7:0] b, input logic eoi);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: b, end_of_input: eoi};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(b, 1'b0);
    endtask

    // end of stream; the byte lane carries junk that the block must not echo
    task automatic send_end();
        push_item(8'($urandom), 1'b1);
    endtask

    // sender holds off until every outstanding byte has its result
    task automatic quiet_and_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input fqp_pkg::t_cfg_index idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // only the low nibble of len_word counts; upper bits are noise on purpose
    task automatic set_terminator(input logic [63:0] pat, input logic [63:0] len_word);
        quiet_and_drain();
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(fqp_pkg::CFG_TERM_PATTERN, pat);
            cfg_write(fqp_pkg::CFG_TERM_LENGTH, len_word);
        end else begin
            cfg_write(fqp_pkg::CFG_TERM_LENGTH, len_word);
            cfg_write(fqp_pkg::CFG_TERM_PATTERN, pat);
        end
        cfg_valid <= 1'b0;
        term_pat  = pat;
        term_used = len_word[3:0];
        if (term_used == 0) term_used = 1;
        if (term_used > fqp_pkg::PAT_MAX) term_used = fqp_pkg::PAT_MAX;
        settings_used++;
    endtask

    // One FASTQ record with random content: header junk, identifier, sequence,
    // the current terminator and a matching quality line. Some records are cut
    // short by end of stream, some are followed by it.
    task automatic send_record();
        logic [7:0]  rec [$];
        logic [7:0]  b;
        int unsigned n;
        int unsigned k;
        int unsigned cut;
        int unsigned mode;
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                b = fqp_pkg::CHAR_NL;
            end else begin
                do b = 8'($urandom); while (b == fqp_pkg::CHAR_AT);
            end
            rec.push_back(b);
        end
        rec.push_back(fqp_pkg::CHAR_AT);
        n = $urandom_range(0, 6);
        for (k = 0; k < n; k++) begin
            do b = 8'($urandom); while (b == fqp_pkg::CHAR_NL);
            rec.push_back(b);
        end
        rec.push_back(fqp_pkg::CHAR_NL);
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) rec.push_back(8'($urandom));
            else rec.push_back(BASES[8*$urandom_range(0, 4) +: 8]);
        end
        for (k = 0; k < term_used; k++) rec.push_back(term_pat[8*k +: 8]);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) rec.push_back(8'($urandom_range(33, 126)));
            else rec.push_back(8'($urandom));
        end
        mode = $urandom_range(0, 99);
        cut  = (mode < 8) ? $urandom_range(1, rec.size() - 1) : rec.size();
        for (k = 0; k < cut; k++) send_byte(rec[k]);
        if (mode < 12) send_end();
    endtask

    initial begin : stim
        int ph_idx;
        int goal;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = fqp_pkg::CFG_TERM_PATTERN;
        cfg_data       = '0;
        hang_cycles    = 0;
        bytes_sent     = 0;
        settings_used  = 1;
        src_idle_pct   = 32;
        sink_stall_pct = 50;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed stream with the reset terminator "\n+\n"
        send_byte("x");                 // dropped while searching
        send_byte(fqp_pkg::CHAR_NL);    // newline before any '@'
        send_end();                     // end of stream in header search: no effect
        send_byte(fqp_pkg::CHAR_AT); send_byte("A"); send_byte(fqp_pkg::CHAR_NL);
        send_byte(8'h00); send_byte(8'hFF);                 // byte extremes as sequence
        send_byte(fqp_pkg::CHAR_NL); send_byte("+"); send_byte(fqp_pkg::CHAR_NL);
        send_byte(fqp_pkg::CHAR_NL); send_byte(8'hFF);      // quality: newline counts
        send_byte(fqp_pkg::CHAR_AT); send_byte(fqp_pkg::CHAR_NL); // empty sequence:
        send_byte(fqp_pkg::CHAR_NL); send_byte("+");              // done on the
        send_byte(fqp_pkg::CHAR_NL);                              // terminator
        send_byte(fqp_pkg::CHAR_AT); send_byte("Z"); send_end();  // early end in identifier
        send_byte(fqp_pkg::CHAR_AT); send_byte(fqp_pkg::CHAR_NL); send_byte("G");
        send_end();                                               // early end in sequence

        // Random records under six terminator settings. Idling profile:
        // receiver-heavy, then sender-heavy, then none.
        for (ph_idx = 0; ph_idx < 6; ph_idx++) begin
            quiet_and_drain();
            src_idle_pct   = (ph_idx < 2) ? 32 : (ph_idx < 4) ? 50 : 0;
            sink_stall_pct = (ph_idx < 2) ? 50 : (ph_idx < 4) ? 32 : 0;
            case (ph_idx)
                0: set_terminator({{7{8'($urandom)}}, fqp_pkg::CHAR_NL}, 64'd1);
                1: set_terminator({$urandom, $urandom}, 64'd8);
                2: set_terminator({$urandom, $urandom}, 64'd0);         // clamps to 1
                3: set_terminator({64{1'b1}}, 64'd15);                  // clamps to 8
                4: set_terminator(64'd0, 64'd2);                        // zero bytes end it
                default: set_terminator(fqp_pkg::TERM_PATTERN_RESET,
                                        {$urandom, 28'($urandom), 4'd3});
            endcase
            goal = bytes_sent + 200;
            while (bytes_sent < goal) begin
                send_record();
                if ($urandom_range(0, 49) == 0) quiet_and_drain();
            end
        end

        quiet_and_drain();
        repeat (4) @(negedge clk);
        $display("fastq_record_parser_core_tb: %0d transactions checked, %0d records complete,",
                 results, records);
        $display("  %0d terminator settings, missing '@', early end and empty sequences",
                 settings_used);
        if (errors == 0 && pending == 0) begin
            $display("fastq_record_parser_core_tb: done, clean");
        end else begin
            $display("fastq_record_parser_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
